// ----- sv/lkvc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the LRU key/value cache: field widths, request codes and
// parameter defaults. Used by the channel interfaces and the top level.
package lkvc_pkg;

    localparam int EntriesDef = 16;
    localparam int KeyBitsDef = 32;

    localparam int KeyW  = 32;
    localparam int DataW = 32;
    localparam int CapW  = 5;

    localparam logic [CapW-1:0]  CapReset = 5'd16;
    localparam logic [DataW-1:0] MinusOne = 32'hFFFF_FFFF;

    localparam logic ModeGet = 1'b0;
    localparam logic ModeSet = 1'b1;

endpackage

// ----- sv/lkvc_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the LRU key/value cache: the request
// channel and the response channel. Depends on lkvc_pkg.
interface lkvc_req_if;
    logic                              valid;
    logic                              ready;
    logic                              mode;
    logic signed [lkvc_pkg::KeyW-1:0]  key;
    logic signed [lkvc_pkg::DataW-1:0] value;

    modport source (output valid, output mode, output key, output value, input ready);
    modport sink (input valid, input mode, input key, input value, output ready);
endinterface

interface lkvc_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              found;
    logic signed [lkvc_pkg::DataW-1:0] read_value;
    logic                              evicted;

    modport source (output valid, output found, output read_value, output evicted,
                    input ready);
    modport sink (input valid, input found, input read_value, input evicted,
                  output ready);
endinterface

// ----- sv/lru_key_value_cache.sv -----
`timescale 1ns / 1ps
// Top level of the fully associative LRU key/value cache.
// Depends on lkvc_pkg and the channel interfaces in lkvc_ifs.sv.
//
// Usage: requests arrive on i_req (mode 0 = get, 1 = set, key, value) and each
// produces one response on o_rsp (found, read_value, evicted). A request is
// taken when valid and ready are both high; ready is high while the engine is
// idle, also while an earlier response still waits in the output register.
// The entries (key, data, recency rank) live in one synchronous memory with a
// registered read; valid bits and the fill count are flip-flops.
// A request makes one pass over the memory to find the hit, a free entry and
// the least recent entry, then, on a hit, a fill or an eviction, a second
// read-modify-write pass that updates the ranks. The next request is taken
// once the engine is back in idle: after the second pass, or, when no second
// pass is needed (a get that misses), after the response is loaded. The two
// passes run in turn through the single entry memory.
// The response is loaded into the output register at the end of the first
// pass; if the receiver stalls and the register is still full, the engine
// waits there. Reset empties the cache at once and sets capacity to 16.
// i_cfg_we/i_cfg_wdata write the capacity; write it only while the cache is idle (not enforced by the block).
module lru_key_value_cache #(
    parameter int ENTRIES  = lkvc_pkg::EntriesDef,
    parameter int KEY_BITS = lkvc_pkg::KeyBitsDef
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lkvc_pkg::CapW-1:0] i_cfg_wdata,
    lkvc_req_if.sink                  i_req,
    lkvc_rsp_if.source                o_rsp
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AW = IW;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int KW = (KEY_BITS < lkvc_pkg::KeyW) ? KEY_BITS : lkvc_pkg::KeyW;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_RESULT = 4'b0100,
        ST_UPDATE = 4'b1000
    } t_state;

    typedef struct packed {
        logic [KW-1:0]             key;
        logic [lkvc_pkg::DataW-1:0] data;
        logic [AW-1:0]             age;
    } t_entry;

    t_state                     r_state;
    t_state                     n_state;
    t_entry                     r_mem [ENTRIES];
    t_entry                     r_rd;
    t_entry                     wr_entry;
    logic [ENTRIES-1:0]         r_valid;
    logic [CW-1:0]              r_occ;
    logic [lkvc_pkg::CapW-1:0]  r_capacity;
    logic [CW-1:0]              r_cnt;
    logic                       r_vld;
    logic [IW-1:0]              r_idx;

    logic                       r_mode;
    logic [KW-1:0]              r_key;
    logic [lkvc_pkg::DataW-1:0] r_value;

    logic                       r_hit;
    logic [IW-1:0]              r_hit_idx;
    logic [AW-1:0]              r_hit_age;
    logic [lkvc_pkg::DataW-1:0] r_hit_data;
    logic                       r_have_vic;
    logic [IW-1:0]              r_vic_idx;
    logic [AW-1:0]              r_vic_age;
    logic                       r_have_free;
    logic [IW-1:0]              r_free_idx;

    logic [IW-1:0]              r_tgt;
    logic [CW-1:0]              r_thr;
    logic                       r_wr_kd;

    logic                       r_rsp_valid;
    logic                       r_found;
    logic [lkvc_pkg::DataW-1:0] r_read_value;
    logic                       r_evicted;

    logic accept;
    logic issue;
    logic pass_done;
    logic ent_valid;
    logic is_set;
    logic has_room;
    logic act_fill;
    logic act_evict;
    logic act_upd;
    logic out_free;
    logic wr_en;

    assign accept    = i_req.valid && i_req.ready;
    assign issue     = (r_state inside {ST_SCAN, ST_UPDATE}) && (r_cnt < CW'(ENTRIES));
    assign pass_done = (r_cnt == CW'(ENTRIES)) && !r_vld;
    assign ent_valid = r_valid[r_idx];
    assign is_set    = (r_mode == lkvc_pkg::ModeSet);
    assign has_room  = ((32'(r_occ) < 32'(r_capacity)) ||
                        ((r_capacity == '0) && (r_occ == '0))) &&
                       (32'(r_occ) < 32'(ENTRIES));
    assign act_fill  = is_set && !r_hit && has_room;
    assign act_evict = is_set && !r_hit && !has_room && r_have_vic;
    assign act_upd   = r_hit || act_fill || act_evict;
    assign out_free  = !r_rsp_valid || o_rsp.ready;
    assign wr_en     = (r_state == ST_UPDATE) && r_vld;

    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.found      = r_found;
    assign o_rsp.read_value = r_read_value;
    assign o_rsp.evicted    = r_evicted;

    always_comb begin
        wr_entry = r_rd;
        if (r_idx == r_tgt) begin
            if (r_wr_kd) begin
                wr_entry.key  = r_key;
                wr_entry.data = r_value;
            end
            wr_entry.age = '0;
        end else if (ent_valid && (CW'(r_rd.age) < r_thr)) begin
            wr_entry.age = r_rd.age + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd <= r_mem[r_cnt[IW-1:0]];
        end
        if (wr_en) begin
            r_mem[r_idx] <= wr_entry;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (pass_done) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_state = act_upd ? ST_UPDATE : ST_IDLE;
                end
            end
            ST_UPDATE: begin
                if (pass_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_occ       <= '0;
            r_capacity  <= lkvc_pkg::CapReset;
            r_cnt       <= '0;
            r_vld       <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_hit       <= 1'b0;
            r_have_vic  <= 1'b0;
            r_have_free <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= issue;
            if (issue) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if ((r_state == ST_RESULT) && out_free) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cnt       <= '0;
                        r_hit       <= 1'b0;
                        r_have_vic  <= 1'b0;
                        r_have_free <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (r_vld) begin
                        if (ent_valid && (r_rd.key == r_key) && !r_hit) begin
                            r_hit <= 1'b1;
                        end
                        if (ent_valid && (!r_have_vic || (r_rd.age > r_vic_age))) begin
                            r_have_vic <= 1'b1;
                        end
                        if (!ent_valid && !r_have_free) begin
                            r_have_free <= 1'b1;
                        end
                    end
                end
                ST_RESULT: begin
                    if (out_free) begin
                        r_cnt <= '0;
                        if (act_fill) begin
                            r_valid[r_free_idx] <= 1'b1;
                            r_occ               <= r_occ + CW'(1);
                        end
                    end
                end
                ST_UPDATE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_req.mode;
            r_key   <= KW'(i_req.key);
            r_value <= i_req.value;
        end
        if (issue) begin
            r_idx <= r_cnt[IW-1:0];
        end
        if ((r_state == ST_SCAN) && r_vld) begin
            if (ent_valid && (r_rd.key == r_key) && !r_hit) begin
                r_hit_idx  <= r_idx;
                r_hit_age  <= r_rd.age;
                r_hit_data <= r_rd.data;
            end
            if (ent_valid && (!r_have_vic || (r_rd.age > r_vic_age))) begin
                r_vic_idx <= r_idx;
                r_vic_age <= r_rd.age;
            end
            if (!ent_valid && !r_have_free) begin
                r_free_idx <= r_idx;
            end
        end
        if ((r_state == ST_RESULT) && out_free) begin
            r_found      <= r_hit;
            r_read_value <= (!is_set && r_hit) ? r_hit_data : lkvc_pkg::MinusOne;
            r_evicted    <= act_evict;
            r_wr_kd      <= is_set;
            if (r_hit) begin
                r_tgt <= r_hit_idx;
                r_thr <= CW'(r_hit_age);
            end else if (act_fill) begin
                r_tgt <= r_free_idx;
                r_thr <= r_occ;
            end else begin
                r_tgt <= r_vic_idx;
                r_thr <= CW'(r_vic_age);
            end
        end
    end

    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_occ))
        else $error("fill count differs from number of valid entries");

    a_occ_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_occ) <= 32'(ENTRIES))
        else $error("fill count exceeds entry count");

    a_hit_never_evicts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid |-> !(r_found && r_evicted))
        else $error("response reports both a hit and an eviction");

    a_fill_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && out_free && act_fill) |-> r_have_free)
        else $error("fill chosen without a free entry");

    a_pass_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_UPDATE) |-> (32'(r_cnt) <= 32'(ENTRIES)))
        else $error("pass counter ran past the last entry");

endmodule

// ----- verif/tb_lru_key_value_cache.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_value_cache: directed and random get/set
// requests under several idle patterns, checked against an LRU model held here.
// Depends on lkvc_pkg, lkvc_ifs.sv and the lru_key_value_cache top level.
module tb_lru_key_value_cache;

    localparam int Entries   = lkvc_pkg::EntriesDef;
    localparam int DrainWait = 2 * Entries + 12;

    typedef struct packed {
        logic                       found;
        logic [lkvc_pkg::DataW-1:0] read_value;
        logic                       evicted;
    } t_lookup_result;

    typedef enum {
        FLOW_FREE,
        SRC_IDLE,
        SNK_STALL,
        BOTH_IDLE
    } t_idle_mode;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [lkvc_pkg::CapW-1:0]  i_cfg_wdata;

    lkvc_req_if req_ch ();
    lkvc_rsp_if rsp_ch ();

    lru_key_value_cache uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    logic                       cache_valid [Entries];
    logic [lkvc_pkg::KeyW-1:0]  cache_key   [Entries];
    logic [lkvc_pkg::DataW-1:0] cache_data  [Entries];
    int                         cache_age   [Entries];
    int                         cache_fill;
    logic [lkvc_pkg::CapW-1:0]  cache_cap;

    t_lookup_result             lookup_results_q[$];
    logic [lkvc_pkg::KeyW-1:0]  key_pool[32];
    t_idle_mode                 idle_mode = FLOW_FREE;
    int                         rsp_hold  = 0;
    int                         err_count = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit send_pause();
        case (idle_mode)
            SRC_IDLE:  return $urandom_range(99) < 83;
            BOTH_IDLE: return $urandom_range(99) < 14;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit recv_stall();
        case (idle_mode)
            SNK_STALL: return $urandom_range(99) < 83;
            BOTH_IDLE: return $urandom_range(99) < 14;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic void move_to_front(input int idx);
        int i;
        int old_age;
        old_age = cache_age[idx];
        for (i = 0; i < Entries; i++) begin
            if (cache_valid[i] && i != idx && cache_age[i] < old_age) begin
                cache_age[i]++;
            end
        end
        cache_age[idx] = 0;
    endfunction

    function automatic t_lookup_result lru_lookup(input logic op,
                                                  input logic [lkvc_pkg::KeyW-1:0] key,
                                                  input logic [lkvc_pkg::DataW-1:0] value);
        t_lookup_result res;
        int i;
        int hit_idx;
        int slot;
        int victim;
        int limit;
        res.found      = 1'b0;
        res.read_value = lkvc_pkg::MinusOne;
        res.evicted    = 1'b0;
        hit_idx = -1;
        for (i = 0; i < Entries; i++) begin
            if (hit_idx < 0 && cache_valid[i] && cache_key[i] == key) begin
                hit_idx = i;
            end
        end
        limit = (cache_cap == 0) ? 1 : ((cache_cap > Entries) ? Entries : int'(cache_cap));
        if (hit_idx >= 0) begin
            res.found = 1'b1;
            if (op == lkvc_pkg::ModeGet) begin
                res.read_value = cache_data[hit_idx];
            end else begin
                cache_data[hit_idx] = value;
            end
            move_to_front(hit_idx);
        end else if (op == lkvc_pkg::ModeSet) begin
            if (cache_fill < limit) begin
                slot = -1;
                for (i = 0; i < Entries; i++) begin
                    if (slot < 0 && !cache_valid[i]) begin
                        slot = i;
                    end
                end
                for (i = 0; i < Entries; i++) begin
                    if (cache_valid[i]) begin
                        cache_age[i]++;
                    end
                end
                cache_valid[slot] = 1'b1;
                cache_key[slot]   = key;
                cache_data[slot]  = value;
                cache_age[slot]   = 0;
                cache_fill++;
            end else begin
                victim = -1;
                for (i = 0; i < Entries; i++) begin
                    if (cache_valid[i] && (victim < 0 || cache_age[i] > cache_age[victim])) begin
                        victim = i;
                    end
                end
                cache_key[victim]  = key;
                cache_data[victim] = value;
                move_to_front(victim);
                res.evicted = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic send_request(input logic op, input logic [lkvc_pkg::KeyW-1:0] key,
                                input logic [lkvc_pkg::DataW-1:0] value);
        while (send_pause()) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.mode  = op;
        req_ch.key   = key;
        req_ch.value = value;
        forever begin
            @(posedge i_clk);
            if (req_ch.ready === 1'b1) begin
                break;
            end
        end
        lookup_results_q.push_back(lru_lookup(op, key, value));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        req_ch.valid = 1'b0;
        while (lookup_results_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DrainWait) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [lkvc_pkg::CapW-1:0] cap);
        wait_idle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = cap;
        @(posedge i_clk);
        cache_cap = cap;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [lkvc_pkg::KeyW-1:0] pick_key(input int pool_size);
        if ($urandom_range(9) == 0) begin
            return $urandom;
        end
        return key_pool[$urandom_range(pool_size - 1)];
    endfunction

    task automatic test_basic_lookup();
        idle_mode = FLOW_FREE;
        send_request(lkvc_pkg::ModeGet, 32'h8000_0000, 32'h0000_0000);
        send_request(lkvc_pkg::ModeSet, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(lkvc_pkg::ModeSet, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(lkvc_pkg::ModeSet, 32'h0000_0000, 32'h0000_0000);
        send_request(lkvc_pkg::ModeSet, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(lkvc_pkg::ModeGet, 32'h7FFF_FFFF, 32'h1234_5678);
        send_request(lkvc_pkg::ModeGet, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(lkvc_pkg::ModeSet, 32'h0000_0000, 32'h1234_5678);
        send_request(lkvc_pkg::ModeGet, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(lkvc_pkg::ModeGet, 32'h0000_0001, 32'h0000_0000);
    endtask

    task automatic test_capacity_corners();
        // Zero acts as one entry, and the cache already holds more than that.
        write_capacity(5'd0);
        send_request(lkvc_pkg::ModeSet, 32'h0000_0005, 32'hA5A5_A5A5);
        send_request(lkvc_pkg::ModeGet, 32'h0000_0005, 32'h0000_0000);
        send_request(lkvc_pkg::ModeGet, 32'h8000_0000, 32'h0000_0000);
        write_capacity(5'd31);
        send_request(lkvc_pkg::ModeSet, 32'h0000_0006, 32'h5A5A_5A5A);
        send_request(lkvc_pkg::ModeSet, 32'h0000_0007, 32'h0F0F_0F0F);
        write_capacity(5'd2);
        send_request(lkvc_pkg::ModeSet, 32'h0000_0008, 32'hF0F0_F0F0);
        send_request(lkvc_pkg::ModeGet, 32'h0000_0006, 32'h0000_0000);
        send_request(lkvc_pkg::ModeGet, 32'h7FFF_FFFF, 32'h0000_0000);
    endtask

    task automatic test_random(input int count, input t_idle_mode mode_sel,
                               input logic [lkvc_pkg::CapW-1:0] cap, input int pool_size);
        write_capacity(cap);
        idle_mode = mode_sel;
        repeat (count) begin
            send_request(logic'($urandom_range(1)), pick_key(pool_size), $urandom);
        end
        idle_mode = FLOW_FREE;
    endtask

    task automatic test_backpressure();
        write_capacity(5'd8);
        idle_mode = FLOW_FREE;
        rsp_hold  = 300;
        repeat (30) send_request(logic'($urandom_range(1)), pick_key(12), $urandom);
        wait_idle();
        repeat (10) send_request(logic'($urandom_range(1)), pick_key(12), $urandom);
    endtask

    always @(negedge i_clk) begin
        if (rsp_hold > 0) begin
            rsp_ch.ready = 1'b0;
            rsp_hold--;
        end else begin
            rsp_ch.ready = !recv_stall();
        end
    end

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (lookup_results_q.size() == 0) begin
                $display("%0t: response with no request pending, got found=%b value=%h evicted=%b",
                         $time, rsp_ch.found, rsp_ch.read_value, rsp_ch.evicted);
                err_count++;
            end else begin
                want = lookup_results_q.pop_front();
                if (rsp_ch.found !== want.found) begin
                    $display("%0t: found mismatch, expected %b, got %b",
                             $time, want.found, rsp_ch.found);
                    err_count++;
                end
                if (rsp_ch.read_value !== want.read_value) begin
                    $display("%0t: read_value mismatch, expected %h, got %h",
                             $time, want.read_value, rsp_ch.read_value);
                    err_count++;
                end
                if (rsp_ch.evicted !== want.evicted) begin
                    $display("%0t: evicted mismatch, expected %b, got %b",
                             $time, want.evicted, rsp_ch.evicted);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("** lru_key_value_cache: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        req_ch.valid = 1'b0;
        req_ch.mode  = lkvc_pkg::ModeGet;
        req_ch.key   = '0;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i < Entries; i++) begin
            cache_valid[i] = 1'b0;
            cache_key[i]   = '0;
            cache_data[i]  = '0;
            cache_age[i]   = 0;
        end
        cache_fill = 0;
        cache_cap  = lkvc_pkg::CapReset;
        for (int i = 0; i < 32; i++) begin
            key_pool[i] = $urandom;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_basic_lookup();
        test_capacity_corners();
        test_random(100, FLOW_FREE, 5'd16, 24);
        test_random(80, SRC_IDLE, 5'd4, 8);
        test_random(80, SNK_STALL, 5'd1, 3);
        test_random(80, BOTH_IDLE, 5'd31, 20);
        test_backpressure();
        wait_idle();

        if (err_count == 0 && lookup_results_q.size() == 0) begin
            $display("** lru_key_value_cache: PASSED **");
        end else begin
            $display("** lru_key_value_cache: FAILED **");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/lkvc_pkg.sv
sv/lkvc_ifs.sv
sv/lru_key_value_cache.sv
verif/tb_lru_key_value_cache.sv
